// File: rtl/core/stepper_command_decoder_macros.svh
// ----------------------------------------------------------------------------
// stepper command decoder assertion macros
// checks sampled on i_clk and switched off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef STEPPER_COMMAND_DECODER_MACROS_SVH
`define STEPPER_COMMAND_DECODER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// word types, command codes and character constants of the command decoder
// ----------------------------------------------------------------------------
package scd_pkg;

    // input word: one message character or an end of message marker
    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } t_in_word;

    // output word: one decoded motor command
    typedef struct packed {
        logic [1:0]  command_kind;
        logic        disable_level;
        logic        direction_level;
        logic [14:0] pulse_count;
        logic        pulse_forever;
        logic [10:0] speed_hz;
    } t_out_word;

    // message state gathered over the characters of one message
    typedef struct packed {
        logic [1:0]  char_position;
        logic [7:0]  first_letter;
        logic [7:0]  second_letter;
        logic        third_is_f;
        logic [14:0] number_value;
        logic        number_bad;
    } t_msg_state;

    // command kinds
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_STOP    = 2'd1;
    localparam logic [1:0] KIND_TURN    = 2'd2;
    localparam logic [1:0] KIND_SPEED   = 2'd3;

    // characters seen so far, saturating
    localparam logic [1:0] POS_NONE = 2'd0;
    localparam logic [1:0] POS_ONE  = 2'd1;
    localparam logic [1:0] POS_TWO  = 2'd2;
    localparam logic [1:0] POS_MORE = 2'd3;

    // action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // lower-case letters and digit bounds
    localparam logic [7:0] CHAR_S    = 8'h73;
    localparam logic [7:0] CHAR_T    = 8'h74;
    localparam logic [7:0] CHAR_V    = 8'h76;
    localparam logic [7:0] CHAR_R    = 8'h72;
    localparam logic [7:0] CHAR_L    = 8'h6c;
    localparam logic [7:0] CHAR_F    = 8'h66;
    localparam logic [7:0] CHAR_M    = 8'h6d;
    localparam logic [7:0] CHAR_C    = 8'h63;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // numeric limits and fixed speeds
    localparam logic [14:0] COUNT_MAX  = 15'd32767;
    localparam logic [10:0] SPEED_MIN  = 11'd16;
    localparam logic [10:0] SPEED_MAX  = 11'd2047;
    localparam logic [10:0] SPEED_FAST = 11'd1500;
    localparam logic [10:0] SPEED_TOP  = 11'd2000;
    localparam logic [10:0] SPEED_MID  = 11'd1000;
    localparam logic [10:0] SPEED_SLOW = 11'd500;

    // case-insensitive letter match against a lower-case letter
    function automatic logic is_letter(input logic [7:0] c, input logic [7:0] lower);
        is_letter = ((c | CASE_BIT) == lower);
    endfunction

endpackage

// File: rtl/core/stepper_command_decoder.sv
`timescale 1ns / 1ps
`include "stepper_command_decoder_macros.svh"
// ----------------------------------------------------------------------------
// stepper_command_decoder
// decodes text motor commands, one character per input word, into one
// command word per message
// ----------------------------------------------------------------------------
// usage:
//   input channel: i_in_valid / o_in_stall carry i_in_word; a word with
//   action low is a message character, action high ends the message
//   output channel: o_out_valid / i_out_stall carry o_out_word, one word
//   per end of message and none per character
//   throughput: one input word per cycle unless an end of message waits on
//   a held result; the input register, the message state and the result
//   register each take one step per cycle; an accepted end of message goes
//   from the input register into the result register, then on o_out_valid
//   stall: while the result is held, a character still passes into the
//   message state; an end of message waits in the input register, and
//   o_in_stall rises only once that register is full and blocked
//   reset: synchronous and active low; clears both valid flags and the
//   message state, so the next word starts a new message
// ----------------------------------------------------------------------------
module stepper_command_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  scd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output scd_pkg::t_out_word o_out_word
);
    import scd_pkg::*;

    logic       r_in_vld;
    t_in_word   r_in;
    logic       r_out_vld;
    t_out_word  r_out;
    logic       n_in_vld;
    logic       n_out_vld;

    logic       in_accept;
    logic       out_free;
    logic       s1_adv;
    logic       take_char;
    logic       end_msg;
    t_msg_state st;
    t_out_word  n_out;
    logic       have2;
    logic       bare;
    logic       sec_r;
    logic       sec_l;

    // handshake control
    always_comb begin
        out_free   = !r_out_vld || !i_out_stall;
        s1_adv     = r_in_vld && (r_in.action == ACT_CHAR || out_free);
        take_char  = s1_adv && r_in.action == ACT_CHAR;
        end_msg    = s1_adv && r_in.action == ACT_END;
        o_in_stall = r_in_vld && !s1_adv;
        in_accept  = i_in_valid && !o_in_stall;
        n_in_vld   = in_accept ? 1'b1 : (s1_adv ? 1'b0 : r_in_vld);
        n_out_vld  = end_msg ? 1'b1 : (i_out_stall ? r_out_vld : 1'b0);
    end

    // message state
    scd_msg_state u_msg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take_char),
        .i_clear (end_msg),
        .i_char  (r_in.char_code),
        .o_state (st)
    );

    // command decode from the gathered message
    always_comb begin
        have2 = (st.char_position == POS_TWO) || (st.char_position == POS_MORE);
        bare  = (st.char_position == POS_TWO);
        sec_r = is_letter(st.second_letter, CHAR_R);
        sec_l = is_letter(st.second_letter, CHAR_L);
        n_out = '0;
        n_out.command_kind = KIND_INVALID;
        if (st.char_position != POS_NONE && is_letter(st.first_letter, CHAR_S)) begin
            n_out.command_kind  = KIND_STOP;
            n_out.disable_level = 1'b1;
        end else if (have2 && is_letter(st.first_letter, CHAR_T)) begin
            if ((sec_r || sec_l) && !st.number_bad) begin
                n_out.command_kind    = KIND_TURN;
                n_out.direction_level = sec_l;
                if (bare) begin
                    n_out.pulse_forever = 1'b1;
                end else begin
                    n_out.pulse_count = st.number_value;
                end
            end
        end else if (have2 && is_letter(st.first_letter, CHAR_V)) begin
            if (is_letter(st.second_letter, CHAR_F)) begin
                if (bare) begin
                    n_out.command_kind = KIND_SPEED;
                    n_out.speed_hz     = SPEED_FAST;
                end else if (st.third_is_f) begin
                    n_out.command_kind = KIND_SPEED;
                    n_out.speed_hz     = SPEED_TOP;
                end
            end else if (is_letter(st.second_letter, CHAR_M)) begin
                n_out.command_kind = KIND_SPEED;
                n_out.speed_hz     = SPEED_MID;
            end else if (is_letter(st.second_letter, CHAR_S)) begin
                n_out.command_kind = KIND_SPEED;
                n_out.speed_hz     = SPEED_SLOW;
            end else if (is_letter(st.second_letter, CHAR_C) && !st.number_bad) begin
                n_out.command_kind = KIND_SPEED;
                if (bare || st.number_value < {4'b0, SPEED_MIN}) begin
                    n_out.speed_hz = SPEED_MIN;
                end else if (st.number_value > {4'b0, SPEED_MAX}) begin
                    n_out.speed_hz = SPEED_MAX;
                end else begin
                    n_out.speed_hz = st.number_value[10:0];
                end
            end
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (end_msg) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // checks
    `SCD_ASSERT_SAME(a_stop_word, r_out_vld && r_out.command_kind == KIND_STOP,
        r_out.disable_level && r_out.pulse_count == '0 && !r_out.pulse_forever
        && r_out.speed_hz == '0, "malformed stop word")
    `SCD_ASSERT_SAME(a_forever_turn, r_out_vld && r_out.pulse_forever,
        r_out.command_kind == KIND_TURN && r_out.pulse_count == '0,
        "endless pulsing outside a bare turn")
    `SCD_ASSERT_SAME(a_speed_range, r_out_vld && r_out.command_kind == KIND_SPEED,
        r_out.speed_hz >= SPEED_MIN && !r_out.disable_level,
        "set speed word below minimum")

endmodule

// File: rtl/core/scd_msg_state.sv
`timescale 1ns / 1ps
`include "stepper_command_decoder_macros.svh"
// ----------------------------------------------------------------------------
// scd_msg_state
// collects letters, third-character flag and saturating decimal value of one
// message; cleared when the message is decoded
// ----------------------------------------------------------------------------
module scd_msg_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_clear,
    input  logic [7:0]          i_char,
    output scd_pkg::t_msg_state o_state
);
    import scd_pkg::*;

    t_msg_state  r_st;
    t_msg_state  n_st;
    logic        is_digit;
    logic [3:0]  digit;
    logic [18:0] scaled;

    // times-ten accumulate with saturation
    always_comb begin
        is_digit = (i_char >= CHAR_0) && (i_char <= CHAR_9);
        digit    = 4'(i_char - CHAR_0);
        scaled   = {4'b0, r_st.number_value} * 19'd10 + {15'b0, digit};
    end

    // next message state
    always_comb begin
        n_st = r_st;
        if (i_clear) begin
            n_st = '0;
        end else if (i_take) begin
            case (r_st.char_position)
                POS_NONE: n_st.first_letter  = i_char;
                POS_ONE:  n_st.second_letter = i_char;
                POS_TWO, POS_MORE: begin
                    if (r_st.char_position == POS_TWO && is_letter(i_char, CHAR_F)) begin
                        n_st.third_is_f = 1'b1;
                    end
                    if (is_digit) begin
                        n_st.number_value = (scaled > {4'b0, COUNT_MAX}) ? COUNT_MAX
                                                                         : scaled[14:0];
                    end else begin
                        n_st.number_bad = 1'b1;
                    end
                end
                default: n_st = r_st;
            endcase
            if (r_st.char_position != POS_MORE) begin
                n_st.char_position = r_st.char_position + 2'd1;
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

    // checks
    `SCD_ASSERT_NEXT(a_clear_empties, i_clear, r_st.char_position == POS_NONE && !r_st.number_bad,
        "message state not cleared")
    `SCD_ASSERT_NEXT(a_position_steps, i_take && !i_clear && r_st.char_position != POS_MORE,
        r_st.char_position == $past(r_st.char_position) + 2'd1, "character position skipped")
    `SCD_ASSERT_SAME(a_no_early_number, r_st.char_position == POS_NONE
        || r_st.char_position == POS_ONE,
        r_st.number_value == '0 && !r_st.number_bad && !r_st.third_is_f,
        "number state set before third character")

endmodule
